FILE: design/tuv_pkg.sv
// ----------------------------------------------------------------------------
// Texture UV transform and wrap: shared definitions
// Register map, wrap mode codes, configuration and inter-stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tuv_pkg;

    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 5;
    localparam int FRAC_BITS_DEF = 16;

    // Register indexes (byte address is 4 times the index).
    localparam logic [2:0] REG_COEF_UU    = 3'd0;
    localparam logic [2:0] REG_COEF_UV    = 3'd1;
    localparam logic [2:0] REG_COEF_UT    = 3'd2;
    localparam logic [2:0] REG_COEF_VU    = 3'd3;
    localparam logic [2:0] REG_COEF_VV    = 3'd4;
    localparam logic [2:0] REG_COEF_VT    = 3'd5;
    localparam logic [2:0] REG_WRAP_MODES = 3'd6;
    localparam logic [2:0] REG_MODE_FLAGS = 3'd7;

    // Per-axis wrap modes.
    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_CLAMP  = 2'd1;
    localparam logic [1:0] WRAP_MIRROR = 2'd2;
    localparam logic [1:0] WRAP_NONE   = 2'd3;

    // Bits of mode_flags.
    localparam int FLAG_FLIP_V = 0;
    localparam int FLAG_MAP_EN = 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_uu;
        logic signed [DATA_W-1:0] coef_uv;
        logic signed [DATA_W-1:0] coef_ut;
        logic signed [DATA_W-1:0] coef_vu;
        logic signed [DATA_W-1:0] coef_vv;
        logic signed [DATA_W-1:0] coef_vt;
        logic [3:0]               wrap_modes;
        logic [1:0]               mode_flags;
    } cfg_t;

    // Item leaving the affine stages: raw input kept for the bypass path.
    typedef struct packed {
        logic signed [DATA_W-1:0] u_raw;
        logic signed [DATA_W-1:0] v_raw;
        logic signed [DATA_W-1:0] u_aff;
        logic signed [DATA_W-1:0] v_aff;
    } aff_t;

endpackage

`default_nettype wire

FILE: design/tuv_cfg_regs.sv
// ----------------------------------------------------------------------------
// Texture UV transform and wrap: configuration registers
// APB-style register file holding the affine matrix and mode bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tuv_cfg_regs
    import tuv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) <<< FRAC_BITS;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_COEF_UU:    cfg_next.coef_uu    = pwdata;
                REG_COEF_UV:    cfg_next.coef_uv    = pwdata;
                REG_COEF_UT:    cfg_next.coef_ut    = pwdata;
                REG_COEF_VU:    cfg_next.coef_vu    = pwdata;
                REG_COEF_VV:    cfg_next.coef_vv    = pwdata;
                REG_COEF_VT:    cfg_next.coef_vt    = pwdata;
                REG_WRAP_MODES: cfg_next.wrap_modes = pwdata[3:0];
                REG_MODE_FLAGS: cfg_next.mode_flags = pwdata[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_uu    <= ONE_FX;
            cfg_reg.coef_uv    <= '0;
            cfg_reg.coef_ut    <= '0;
            cfg_reg.coef_vu    <= '0;
            cfg_reg.coef_vv    <= ONE_FX;
            cfg_reg.coef_vt    <= '0;
            cfg_reg.wrap_modes <= 4'd5;
            cfg_reg.mode_flags <= 2'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COEF_UU:    prdata = cfg_reg.coef_uu;
            REG_COEF_UV:    prdata = cfg_reg.coef_uv;
            REG_COEF_UT:    prdata = cfg_reg.coef_ut;
            REG_COEF_VU:    prdata = cfg_reg.coef_vu;
            REG_COEF_VV:    prdata = cfg_reg.coef_vv;
            REG_COEF_VT:    prdata = cfg_reg.coef_vt;
            REG_WRAP_MODES: prdata = {{(DATA_W-4){1'b0}}, cfg_reg.wrap_modes};
            REG_MODE_FLAGS: prdata = {{(DATA_W-2){1'b0}}, cfg_reg.mode_flags};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/tuv_affine.sv
// ----------------------------------------------------------------------------
// Texture UV transform and wrap: affine stages
// Stage 1 forms the four products, stage 2 sums, scales, translates and
// saturates each new coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module tuv_affine
    import tuv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cfg_t                     cfg,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] u_in,
    input  wire logic signed [DATA_W-1:0] v_in,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output aff_t                          out_data
);

    localparam int PW = 2 * DATA_W;     // product width
    localparam int SW = PW + 2;         // sum, shift and translate width

    // Stage 1: products.
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_ready;
    logic signed [PW-1:0]   p_uu_reg;
    logic signed [PW-1:0]   p_uv_reg;
    logic signed [PW-1:0]   p_vu_reg;
    logic signed [PW-1:0]   p_vv_reg;
    logic signed [DATA_W-1:0] s1_u_reg;
    logic signed [DATA_W-1:0] s1_v_reg;

    // Stage 2: affine result.
    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    logic                   s2_ready;
    aff_t                   s2_data_reg;
    aff_t                   s2_data_next;

    function automatic logic signed [DATA_W-1:0] affine_sat(
        input logic signed [PW-1:0]     pa,
        input logic signed [PW-1:0]     pb,
        input logic signed [DATA_W-1:0] t
    );
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] res;
        logic                 all_ones;
        logic                 any_ones;
        sum = $signed({{2{pa[PW-1]}}, pa}) + $signed({{2{pb[PW-1]}}, pb});
        // Arithmetic shift gives floor of the exact quotient.
        res = (sum >>> FRAC_BITS) + $signed({{(SW-DATA_W){t[DATA_W-1]}}, t});
        all_ones = &res[SW-2:DATA_W-1];
        any_ones = |res[SW-2:DATA_W-1];
        if (!res[SW-1] && any_ones)
            affine_sat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (res[SW-1] && !all_ones)
            affine_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            affine_sat = res[DATA_W-1:0];
    endfunction

    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            p_uu_reg <= cfg.coef_uu * u_in;
            p_uv_reg <= cfg.coef_uv * v_in;
            p_vu_reg <= cfg.coef_vu * u_in;
            p_vv_reg <= cfg.coef_vv * v_in;
            s1_u_reg <= u_in;
            s1_v_reg <= v_in;
        end
    end

    always_comb
    begin
        s2_data_next.u_raw = s1_u_reg;
        s2_data_next.v_raw = s1_v_reg;
        s2_data_next.u_aff = affine_sat(p_uu_reg, p_uv_reg, cfg.coef_ut);
        s2_data_next.v_aff = affine_sat(p_vu_reg, p_vv_reg, cfg.coef_vt);
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

`ifndef NO_ASSERTIONS
    // A stalled second stage keeps its result.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ready |=> s2_valid_reg && $stable(s2_data_reg))
        else $error("affine stage 2 lost or changed a held item");
`endif

endmodule

`default_nettype wire

FILE: design/tuv_wrap.sv
// ----------------------------------------------------------------------------
// Texture UV transform and wrap: wrap and output stage
// Applies per-axis wrap modes and the v flip, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tuv_wrap
    import tuv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cfg_t                     cfg,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire aff_t                     in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      u_out,
    output logic signed [DATA_W-1:0]      v_out
);

    localparam logic signed [DATA_W-1:0] ONE_FX    = DATA_W'(1) <<< FRAC_BITS;
    localparam logic        [DATA_W-1:0] FRAC_MASK = ONE_FX - DATA_W'(1);

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     load;
    logic signed [DATA_W-1:0] u_out_reg;
    logic signed [DATA_W-1:0] v_out_reg;
    logic signed [DATA_W-1:0] u_out_next;
    logic signed [DATA_W-1:0] v_out_next;
    logic signed [DATA_W-1:0] u_wrapped;
    logic signed [DATA_W-1:0] v_wrapped;
    logic signed [DATA_W-1:0] v_flipped;

    function automatic logic signed [DATA_W-1:0] wrap_axis(
        input logic signed [DATA_W-1:0] x,
        input logic [1:0]               mode
    );
        logic [DATA_W-1:0] frac;
        logic              odd;
        frac = x & FRAC_MASK;
        odd  = x[FRAC_BITS];
        if (!x[DATA_W-1] && x <= ONE_FX)
            wrap_axis = x;
        else
        begin
            case (mode)
                WRAP_REPEAT: wrap_axis = frac;
                WRAP_CLAMP:  wrap_axis = x[DATA_W-1] ? '0 : ONE_FX;
                WRAP_MIRROR:
                begin
                    // An odd integer part reflects the fraction; whole odd
                    // values land on zero.
                    if (odd)
                        wrap_axis = (frac == '0) ? '0 : ONE_FX - frac;
                    else
                        wrap_axis = frac;
                end
                WRAP_NONE:   wrap_axis = x;
                default:     wrap_axis = x;
            endcase
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] flip_sat(
        input logic signed [DATA_W-1:0] x
    );
        logic signed [DATA_W+1:0] d;
        d = $signed({2'b00, ONE_FX}) - $signed({{2{x[DATA_W-1]}}, x});
        if (!d[DATA_W+1] && (d[DATA_W] || d[DATA_W-1]))
            flip_sat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (d[DATA_W+1] && !(d[DATA_W] && d[DATA_W-1]))
            flip_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            flip_sat = d[DATA_W-1:0];
    endfunction

    assign u_wrapped = wrap_axis(in_data.u_aff, cfg.wrap_modes[1:0]);
    assign v_wrapped = wrap_axis(in_data.v_aff, cfg.wrap_modes[3:2]);
    assign v_flipped = cfg.mode_flags[FLAG_FLIP_V] ? flip_sat(v_wrapped) : v_wrapped;

    always_comb
    begin
        if (cfg.mode_flags[FLAG_MAP_EN])
        begin
            u_out_next = u_wrapped;
            v_out_next = v_flipped;
        end
        else
        begin
            u_out_next = in_data.u_raw;
            v_out_next = in_data.v_raw;
        end
    end

    assign in_ready       = !out_valid_reg || out_ready;
    assign load           = in_valid && in_ready;
    assign out_valid_next = in_ready ? in_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            u_out_reg <= u_out_next;
            v_out_reg <= v_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign u_out     = u_out_reg;
    assign v_out     = v_out_reg;

`ifndef NO_ASSERTIONS
    // Repeat on u always lands inside [0, 1].
    a_u_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        load && cfg.mode_flags[FLAG_MAP_EN] && cfg.wrap_modes[1:0] == WRAP_REPEAT
        |=> !u_out_reg[DATA_W-1] && u_out_reg <= ONE_FX)
        else $error("u repeat result outside the unit range");

    // Clamp on v without flip always lands inside [0, 1].
    a_v_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        load && cfg.mode_flags[FLAG_MAP_EN] && !cfg.mode_flags[FLAG_FLIP_V]
        && cfg.wrap_modes[3:2] == WRAP_CLAMP
        |=> !v_out_reg[DATA_W-1] && v_out_reg <= ONE_FX)
        else $error("v clamp result outside the unit range");
`endif

endmodule

`default_nettype wire

FILE: design/texture_uv_transform_wrap_core.sv
// ----------------------------------------------------------------------------
// Texture UV transform and wrap core
// Affine transform of a Q16.16 (u, v) pair, per-axis wrap and optional v flip.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     u_in, v_in
//   output    out        out_valid / out_stall   u_out, v_out
//   config    in         APB (psel, penable)     paddr, pwdata, prdata
//
// One pair is taken every cycle while in_stall is low; each result passes
// the product, affine sum and saturate, and wrap and output stages before
// it can transfer out. Reset clears the valid bits and loads the identity
// matrix, modes 5 and flags 3. A stall on the output fills the empty stages
// first; in_stall rises only when all three stages hold an item.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_uv_transform_wrap_core
    import tuv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [DATA_W-1:0] u_in,
    input  wire logic signed [DATA_W-1:0] v_in,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      u_out,
    output logic signed [DATA_W-1:0]      v_out,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready
);

    cfg_t cfg;
    aff_t aff_data;
    logic aff_valid;
    logic aff_ready;
    logic in_ready;

    tuv_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tuv_affine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_affine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .u_in      (u_in),
        .v_in      (v_in),
        .out_valid (aff_valid),
        .out_ready (aff_ready),
        .out_data  (aff_data)
    );

    tuv_wrap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (aff_valid),
        .in_ready  (aff_ready),
        .in_data   (aff_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .u_out     (u_out),
        .v_out     (v_out)
    );

    assign in_stall = !in_ready;

`ifndef NO_ASSERTIONS
    // The input can only back up when the output holds a waiting result.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output stage could drain");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_texture_uv_transform_wrap_core.sv
// ----------------------------------------------------------------------------
// Testbench for the texture UV transform and wrap core
// Drives (u, v) pairs with random gaps and output stalls, and sets the
// matrix, wrap modes and flags over the APB port between phases. Each
// result is compared with an independent model of the affine transform,
// the per-axis wrap and the v flip.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_texture_uv_transform_wrap_core;

    timeunit 1ns;
    timeprecision 1ps;

    import tuv_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic signed [DATA_W-1:0] ONE_FX = 32'sd1 <<< FRAC;
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
    } uv_pair_t;

    class uv_wrap_scoreboard;
        cfg_t     regs;
        uv_pair_t expected_pairs[$];
        int       mismatches;

        function new();
            regs            = '0;
            regs.coef_uu    = ONE_FX;
            regs.coef_vv    = ONE_FX;
            regs.wrap_modes = {WRAP_CLAMP, WRAP_CLAMP};
            regs.mode_flags = 2'b11;
            mismatches      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_COEF_UU:    regs.coef_uu = val;
                REG_COEF_UV:    regs.coef_uv = val;
                REG_COEF_UT:    regs.coef_ut = val;
                REG_COEF_VU:    regs.coef_vu = val;
                REG_COEF_VV:    regs.coef_vv = val;
                REG_COEF_VT:    regs.coef_vt = val;
                REG_WRAP_MODES: regs.wrap_modes = val[3:0];
                default:        regs.mode_flags = val[1:0];
            endcase
        endfunction

        // floor((cx*x + cy*y) / 2^FRAC) + t, exact, then saturated to 32 bits.
        function logic signed [DATA_W-1:0] affine_sat(logic signed [DATA_W-1:0] cx,
                                                      logic signed [DATA_W-1:0] x,
                                                      logic signed [DATA_W-1:0] cy,
                                                      logic signed [DATA_W-1:0] y,
                                                      logic signed [DATA_W-1:0] t);
            logic signed [67:0] px;
            logic signed [67:0] py;
            logic signed [67:0] acc;
            px  = cx;
            py  = cy;
            acc = px * x + py * y;
            acc = (acc >>> FRAC) + t;
            if (acc > S32_MAX)
                return S32_MAX;
            if (acc < S32_MIN)
                return S32_MIN;
            return acc[DATA_W-1:0];
        endfunction

        function logic signed [DATA_W-1:0] wrap_coord(logic signed [DATA_W-1:0] x,
                                                      logic [1:0] mode);
            logic signed [DATA_W-1:0] frac;
            frac = x & (ONE_FX - 1);
            if (x >= 0 && x <= ONE_FX)
                return x;
            case (mode)
                WRAP_REPEAT: return frac;
                WRAP_CLAMP:  return (x < 0) ? '0 : ONE_FX;
                WRAP_MIRROR:
                begin
                    // An odd integer part reflects the fraction; odd integers land on 0.
                    if (x[FRAC])
                        return (frac == 0) ? '0 : ONE_FX - frac;
                    return frac;
                end
                default:     return x;
            endcase
        endfunction

        function uv_pair_t transform_pair(logic signed [DATA_W-1:0] u,
                                          logic signed [DATA_W-1:0] v);
            uv_pair_t           r;
            logic signed [33:0] flip;
            r.u = u;
            r.v = v;
            if (regs.mode_flags[FLAG_MAP_EN])
            begin
                r.u = affine_sat(regs.coef_uu, u, regs.coef_uv, v, regs.coef_ut);
                r.v = affine_sat(regs.coef_vu, u, regs.coef_vv, v, regs.coef_vt);
                r.u = wrap_coord(r.u, regs.wrap_modes[1:0]);
                r.v = wrap_coord(r.v, regs.wrap_modes[3:2]);
                if (regs.mode_flags[FLAG_FLIP_V])
                begin
                    flip = ONE_FX;
                    flip = flip - r.v;
                    if (flip > S32_MAX)
                        r.v = S32_MAX;
                    else if (flip < S32_MIN)
                        r.v = S32_MIN;
                    else
                        r.v = flip[DATA_W-1:0];
                end
            end
            return r;
        endfunction

        function void note_pair(logic signed [DATA_W-1:0] u, logic signed [DATA_W-1:0] v);
            expected_pairs.push_back(transform_pair(u, v));
        endfunction

        function void check_pair(logic signed [DATA_W-1:0] u, logic signed [DATA_W-1:0] v);
            uv_pair_t exp_pair;
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none pending, got u %h v %h", $time, u, v);
                return;
            end
            exp_pair = expected_pairs.pop_front();
            if (u !== exp_pair.u)
            begin
                mismatches++;
                $display("%0t: u_out mismatch, expected %h, got %h", $time, exp_pair.u, u);
            end
            if (v !== exp_pair.v)
            begin
                mismatches++;
                $display("%0t: v_out mismatch, expected %h, got %h", $time, exp_pair.v, v);
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] u_in = '0;
    logic signed [DATA_W-1:0] v_in = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] u_out;
    logic signed [DATA_W-1:0] v_out;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    uv_wrap_scoreboard sb = new();
    bit                src_burst = 1'b0;
    bit                sink_burst = 1'b0;
    int                sink_hold = 0;

    texture_uv_transform_wrap_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .u_in      (u_in),
        .v_in      (v_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .u_out     (u_out),
        .v_out     (v_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Output side: check each transfer, then hold stall for a random count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_pair(u_out, v_out);
                sink_hold = sink_burst ? 0 : $urandom_range(0, 4);
            end
            out_stall <= (sink_hold != 0);
            if (sink_hold != 0)
                sink_hold--;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        // An idle wait after each write keeps back-to-back writes apart.
        @(posedge clk);
    endtask

    task automatic load_config(logic [DATA_W-1:0] uu, logic [DATA_W-1:0] uv,
                               logic [DATA_W-1:0] ut, logic [DATA_W-1:0] vu,
                               logic [DATA_W-1:0] vv, logic [DATA_W-1:0] vt,
                               logic [3:0] modes, logic [1:0] flags);
        write_reg(REG_COEF_UU, uu);
        write_reg(REG_COEF_UV, uv);
        write_reg(REG_COEF_UT, ut);
        write_reg(REG_COEF_VU, vu);
        write_reg(REG_COEF_VV, vv);
        write_reg(REG_COEF_VT, vt);
        write_reg(REG_WRAP_MODES, {28'd0, modes});
        write_reg(REG_MODE_FLAGS, {30'd0, flags});
    endtask

    task automatic send_pair(logic signed [DATA_W-1:0] u, logic signed [DATA_W-1:0] v);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        u_in     <= u;
        v_in     <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_pair(u, v);
    endtask

    // Stop sending and let every pending result come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return ONE_FX;
            1:       return -ONE_FX;
            2:       return '0;
            3:       return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
            4:       return $urandom;
            5:       return ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
            default: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
            // Values on and right next to integer boundaries.
            4, 5:       return (($urandom_range(0, 8) - 4) << FRAC) + ($urandom_range(0, 2) - 1);
            6:          return $urandom;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return S32_MAX;
                    1:       return S32_MIN;
                    2:       return '0;
                    default: return ONE_FX;
                endcase
            end
            default:    return $urandom_range(0, ONE_FX);
        endcase
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset configuration: identity, clamp on both axes, flip on.
        send_pair('0, '0);
        send_pair(ONE_FX, ONE_FX);
        send_pair(-32'sd1, ONE_FX + 1);
        send_pair(S32_MAX, S32_MIN);
        send_pair(S32_MIN, S32_MAX);
        drain_results();

        // Repeat on u, mirrored repeat on v, no flip.
        load_config(ONE_FX, 0, 0, 0, ONE_FX, 0, {WRAP_MIRROR, WRAP_REPEAT}, 2'b10);
        send_pair(32'sh2_8000, 32'sh1_8000);
        send_pair(-32'sh8000, 32'sh3_0000);
        send_pair(32'sh5_0000, 32'sh2_4000);
        send_pair(-32'sh3_0000, -32'sh4000);
        send_pair(32'sh1_0001, -32'sh1_0000);
        drain_results();

        // No wrap on either axis; flipping the most negative v saturates.
        load_config(ONE_FX, 0, 0, 0, ONE_FX, 0, {WRAP_NONE, WRAP_NONE}, 2'b11);
        send_pair(S32_MAX, S32_MIN);
        send_pair(S32_MIN, S32_MAX);
        send_pair(32'sh7_1234, -32'sh2_0001);
        drain_results();

        // Mapping off: the pair passes through even with flip set.
        load_config(ONE_FX, 0, 0, 0, ONE_FX, 0, {WRAP_CLAMP, WRAP_CLAMP}, 2'b01);
        send_pair(S32_MIN, S32_MAX);
        send_pair(32'sh5_5555, -32'sh2_AAAA);
        send_pair('0, S32_MIN);
        drain_results();

        // Extreme coefficients: saturation and flooring of negative products.
        load_config(S32_MIN, S32_MIN, S32_MAX, S32_MAX, 32'hFFFF_FFFF, S32_MIN,
                    {WRAP_REPEAT, WRAP_CLAMP}, 2'b11);
        send_pair(S32_MIN, S32_MIN);
        send_pair(32'sd1, 32'sd1);
        send_pair(-32'sd1, 32'sd3);
        send_pair(S32_MAX, S32_MAX);
        drain_results();

        // Fractional coefficients.
        load_config(32'h8000, 32'h1, 32'hFFFF_FFFD, -32'sh8000, 32'h1_8000, ONE_FX,
                    {WRAP_REPEAT, WRAP_MIRROR}, 2'b11);
        send_pair(32'sd3, -32'sd3);
        send_pair(32'sh1_0001, -32'sh1_0001);
        drain_results();

        for (int phase = 0; phase < 14; phase++)
        begin
            load_config(pick_coef(), pick_coef(), pick_coef(),
                        pick_coef(), pick_coef(), pick_coef(),
                        4'($urandom_range(0, 15)),
                        ($urandom_range(0, 3) != 0) ? {1'b1, 1'($urandom_range(0, 1))}
                                                    : {1'b0, 1'($urandom_range(0, 1))});
            // Identity-like matrices keep more results inside the wrap ranges.
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_COEF_UU, ONE_FX);
                write_reg(REG_COEF_VV, ONE_FX);
                write_reg(REG_COEF_UV, 0);
                write_reg(REG_COEF_VU, 0);
            end
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 110; n++)
            begin
                if (phase == 5 && n == 55)
                    drain_results();
                send_pair(pick_coord(), pick_coord());
            end
            drain_results();
            src_burst  = 1'b0;
            sink_burst = 1'b0;
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
